>>> rtl/mm4_pkg.sv
`default_nettype none
package mm4_pkg;

  localparam int DIM    = 4;
  localparam int WORD_W = 32;
  localparam int PROD_W = 2 * WORD_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam int IDX_W  = $clog2(DIM);

  typedef logic [DIM-1:0][WORD_W-1:0] row_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [ACC_W-1:0] acc;
  } tok_t;

  typedef struct packed {
    logic              a_we;
    logic              b_we;
    logic [IDX_W-1:0]  row;
    logic [WORD_W-1:0] a_data;
    row_t              b_data;
  } load_t;

  typedef struct packed {
    logic             row_done;
    logic [IDX_W-1:0] row;
  } fin_stat_t;

endpackage
`default_nettype wire

>>> rtl/mm4_if.sv
`default_nettype none
interface mm4_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [mm4_pkg::WORD_W-1:0]   left_e0;
  logic signed [mm4_pkg::WORD_W-1:0]   left_e1;
  logic signed [mm4_pkg::WORD_W-1:0]   left_e2;
  logic signed [mm4_pkg::WORD_W-1:0]   left_e3;
  logic signed [mm4_pkg::WORD_W-1:0]   right_e0;
  logic signed [mm4_pkg::WORD_W-1:0]   right_e1;
  logic signed [mm4_pkg::WORD_W-1:0]   right_e2;
  logic signed [mm4_pkg::WORD_W-1:0]   right_e3;

  modport source (output valid, left_e0, left_e1, left_e2, left_e3,
                  right_e0, right_e1, right_e2, right_e3, input ready);
  modport sink   (input valid, left_e0, left_e1, left_e2, left_e3,
                  right_e0, right_e1, right_e2, right_e3, output ready);
endinterface

interface mm4_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [mm4_pkg::WORD_W-1:0]   prod_e0;
  logic signed [mm4_pkg::WORD_W-1:0]   prod_e1;
  logic signed [mm4_pkg::WORD_W-1:0]   prod_e2;
  logic signed [mm4_pkg::WORD_W-1:0]   prod_e3;
  logic        [mm4_pkg::IDX_W-1:0]    prod_row;
  logic                                row_overflow;
  logic                                final_row;

  modport source (output valid, prod_e0, prod_e1, prod_e2, prod_e3, prod_row,
                  row_overflow, final_row, input ready);
  modport sink   (input valid, prod_e0, prod_e1, prod_e2, prod_e3, prod_row,
                  row_overflow, final_row, output ready);
endinterface
`default_nettype wire

>>> rtl/matrix4x4_multiply.sv
`default_nettype none
// 4x4 signed Q16.16 matrix multiply, C = A * B. Send rows 0 to 3, each beat
// carrying one row of A and the same row of B. After row 3 the input is held
// off while the four rows of C come out in order, the last one flagged
// final_row. Elements are floored back to Q16.16 and saturated; row_overflow
// marks a row with any clamped element. The work runs through a chain of four
// multiply-add cells, each holding one column of A and one row of B, with two
// register stages per cell. Each product row is issued into the chain one
// element at a time and gathered at the end; the next row is issued only once
// the previous one has moved into the output register, and that move waits
// while an earlier product row is still stalled at the output.
module matrix4x4_multiply #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mm4_in_if.sink     in_ch,
  mm4_out_if.source  out_ch
);

  localparam int DIM   = mm4_pkg::DIM;
  localparam int IDX_W = mm4_pkg::IDX_W;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(DIM - 1);

  typedef enum logic [2:0] {
    S_LOAD  = 3'b001,
    S_ISSUE = 3'b010,
    S_WAIT  = 3'b100
  } state_t;

  state_t                state_r;
  logic [IDX_W-1:0]      load_row_r;
  logic [IDX_W-1:0]      iss_row_r;
  logic [IDX_W-1:0]      iss_col_r;
  logic                  in_acc;
  mm4_pkg::row_t         left_row;
  mm4_pkg::row_t         right_row;
  mm4_pkg::tok_t         chain [DIM+1];
  mm4_pkg::load_t        ld [DIM];
  mm4_pkg::fin_stat_t    fin_stat;

  assign in_ch.ready = (state_r == S_LOAD);
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign left_row[0]  = in_ch.left_e0;
  assign left_row[1]  = in_ch.left_e1;
  assign left_row[2]  = in_ch.left_e2;
  assign left_row[3]  = in_ch.left_e3;
  assign right_row[0] = in_ch.right_e0;
  assign right_row[1] = in_ch.right_e1;
  assign right_row[2] = in_ch.right_e2;
  assign right_row[3] = in_ch.right_e3;

  assign chain[0].valid = (state_r == S_ISSUE);
  assign chain[0].row   = iss_row_r;
  assign chain[0].col   = iss_col_r;
  assign chain[0].acc   = '0;

  for (genvar k = 0; k < DIM; k++) begin : g_cell
    assign ld[k].a_we   = in_acc;
    assign ld[k].b_we   = in_acc && (load_row_r == IDX_W'(k));
    assign ld[k].row    = load_row_r;
    assign ld[k].a_data = left_row[k];
    assign ld[k].b_data = right_row;

    mm4_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ld      (ld[k]),
      .tok_in  (chain[k]),
      .tok_out (chain[k+1])
    );
  end

  mm4_finish #(
    .FRAC_BITS (FRAC_BITS)
  ) u_finish (
    .clk    (clk),
    .rst_n  (rst_n),
    .tok    (chain[DIM]),
    .stat   (fin_stat),
    .out_ch (out_ch)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_LOAD;
      load_row_r <= '0;
      iss_row_r  <= '0;
      iss_col_r  <= '0;
    end else begin
      unique case (state_r)
        S_LOAD: begin
          if (in_acc) begin
            load_row_r <= load_row_r + 1'b1;
            if (load_row_r == LAST) begin
              state_r   <= S_ISSUE;
              iss_row_r <= '0;
              iss_col_r <= '0;
            end
          end
        end
        S_ISSUE: begin
          iss_col_r <= iss_col_r + 1'b1;
          if (iss_col_r == LAST) begin
            state_r <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (fin_stat.row_done) begin
            if (fin_stat.row == LAST) begin
              state_r <= S_LOAD;
            end else begin
              iss_row_r <= iss_row_r + 1'b1;
              state_r   <= S_ISSUE;
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/mm4_cell.sv
`default_nettype none
module mm4_cell (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire mm4_pkg::load_t ld,
  input  wire mm4_pkg::tok_t  tok_in,
  output mm4_pkg::tok_t       tok_out
);

  logic [mm4_pkg::DIM-1:0][mm4_pkg::WORD_W-1:0] a_col_r;
  mm4_pkg::row_t                                b_row_r;
  mm4_pkg::tok_t                                mid_r;
  mm4_pkg::tok_t                                out_r;
  logic signed [mm4_pkg::PROD_W-1:0]            prod_r;
  logic signed [mm4_pkg::WORD_W-1:0]            a_sel;
  logic signed [mm4_pkg::WORD_W-1:0]            b_sel;

  assign a_sel   = a_col_r[tok_in.row];
  assign b_sel   = b_row_r[tok_in.col];
  assign tok_out = out_r;

  always_ff @(posedge clk) begin
    if (ld.a_we) begin
      a_col_r[ld.row] <= ld.a_data;
    end
    if (ld.b_we) begin
      b_row_r <= ld.b_data;
    end
  end

  // multiply, then add onto the partial sum passed down the chain
  always_ff @(posedge clk) begin
    prod_r    <= a_sel * b_sel;
    mid_r.row <= tok_in.row;
    mid_r.col <= tok_in.col;
    mid_r.acc <= tok_in.acc;
    out_r.row <= mid_r.row;
    out_r.col <= mid_r.col;
    out_r.acc <= mid_r.acc +
                 {{(mm4_pkg::ACC_W-mm4_pkg::PROD_W){prod_r[mm4_pkg::PROD_W-1]}}, prod_r};
    if (!rst_n) begin
      mid_r.valid <= 1'b0;
      out_r.valid <= 1'b0;
    end else begin
      mid_r.valid <= tok_in.valid;
      out_r.valid <= mid_r.valid;
    end
  end

endmodule
`default_nettype wire

>>> rtl/mm4_finish.sv
`default_nettype none
module mm4_finish #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire mm4_pkg::tok_t  tok,
  output mm4_pkg::fin_stat_t  stat,
  mm4_out_if.source           out_ch
);

  localparam int ACC_W  = mm4_pkg::ACC_W;
  localparam int WORD_W = mm4_pkg::WORD_W;
  localparam int IDX_W  = mm4_pkg::IDX_W;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(mm4_pkg::DIM - 1);
  localparam logic signed [ACC_W-1:0] SAT_MAX =
    {{(ACC_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_MIN =
    {{(ACC_W-WORD_W+1){1'b1}}, {(WORD_W-1){1'b0}}};

  logic signed [ACC_W-1:0]  acc_s;
  logic signed [ACC_W-1:0]  shr;
  logic [WORD_W-1:0]        sat_val;
  logic                     sat;
  logic                     xfer;

  mm4_pkg::row_t            elem_r;
  logic                     ovf_r;
  logic [IDX_W-1:0]         asm_row_r;
  logic                     asm_full_r;
  mm4_pkg::row_t            out_elem_r;
  logic [IDX_W-1:0]         out_row_r;
  logic                     out_ovf_r;
  logic                     out_final_r;
  logic                     out_vld_r;

  always_comb begin
    acc_s = tok.acc;
    shr   = acc_s >>> FRAC_BITS;
    if (shr > SAT_MAX) begin
      sat     = 1'b1;
      sat_val = SAT_MAX[WORD_W-1:0];
    end else if (shr < SAT_MIN) begin
      sat     = 1'b1;
      sat_val = SAT_MIN[WORD_W-1:0];
    end else begin
      sat     = 1'b0;
      sat_val = shr[WORD_W-1:0];
    end
  end

  assign xfer          = asm_full_r && (!out_vld_r || out_ch.ready);
  assign stat.row_done = xfer;
  assign stat.row      = asm_row_r;

  always_ff @(posedge clk) begin
    if (tok.valid) begin
      elem_r[tok.col] <= sat_val;
      ovf_r           <= (tok.col == '0) ? sat : (ovf_r | sat);
      asm_row_r       <= tok.row;
    end
    if (xfer) begin
      out_elem_r  <= elem_r;
      out_row_r   <= asm_row_r;
      out_ovf_r   <= ovf_r;
      out_final_r <= (asm_row_r == LAST);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      asm_full_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (tok.valid && tok.col == LAST) begin
        asm_full_r <= 1'b1;
      end else if (xfer) begin
        asm_full_r <= 1'b0;
      end
      if (xfer) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.prod_e0      = out_elem_r[0];
  assign out_ch.prod_e1      = out_elem_r[1];
  assign out_ch.prod_e2      = out_elem_r[2];
  assign out_ch.prod_e3      = out_elem_r[3];
  assign out_ch.prod_row     = out_row_r;
  assign out_ch.row_overflow = out_ovf_r;
  assign out_ch.final_row    = out_final_r;

endmodule
`default_nettype wire

>>> rtl/mm4_checker.sv
`default_nettype none
module mm4_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [mm4_pkg::IDX_W-1:0]  out_prod_row,
  input wire logic                       out_final_row
);

  localparam logic [mm4_pkg::IDX_W-1:0] LAST = mm4_pkg::IDX_W'(mm4_pkg::DIM - 1);

  a_final_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_final_row == (out_prod_row == LAST)))
    else $error("final_row does not match the last product row");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_prod_row))
    else $error("stalled output beat changed");

  a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(in_valid && in_ready))
    else $error("input held off without an accepted beat");

  a_ready_after_final: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $rose(in_ready) |-> out_valid && out_final_row)
    else $error("input reopened before the final product row");

endmodule

bind matrix4x4_multiply mm4_checker u_mm4_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_prod_row  (out_ch.prod_row),
  .out_final_row (out_ch.final_row)
);
`default_nettype wire
